FILE: src/c_escape_sequence_decoder_top_macros.svh
// Assertion macros shared by the escape sequence decoder.
`ifndef C_ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle during reset.
`define C_ESC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escape decoder check failed");

// Next-cycle implication, sampled on clk_i and idle during reset.
`define C_ESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escape decoder check failed");

`endif

FILE: src/c_esc_pkg.sv
// Types and constants shared by the escape sequence decoder modules.
package c_esc_pkg;

  // Default depth of the result queue; must hold two words at least.
  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_OCT  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] value;
    logic [1:0] oct_cnt;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       literal_end;
    logic       run_last;
  } res_t;

  // Words produced by one decoded byte, in order; count is 0 to 2.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } dec_push_t;

endpackage

FILE: src/c_esc_if.sv
// Handshake interfaces for the raw byte input and the decoded result output.
interface c_esc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

interface c_esc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       literal_end;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_valid, output literal_end,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input literal_end,
                input run_last, output ready);
endinterface

FILE: src/c_esc_decode.sv
// Escape decoding state register and the per-byte decode logic.
module c_esc_decode (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   is_final_i,
  output c_esc_pkg::dec_push_t   push_o,
  output c_esc_pkg::dec_state_t  state_o
);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_V   = 8'h76;
  localparam logic [1:0] OCT_MAX   = 2'd3;

  localparam c_esc_pkg::dec_state_t STATE_RST = '{
    mode: c_esc_pkg::MODE_TEXT, value: 8'd0, oct_cnt: 2'd0};

  c_esc_pkg::dec_state_t state_q, state_d;
  c_esc_pkg::res_t       res [2];
  logic [1:0]            n_res;
  logic                  is_oct, is_hex, do_plain;
  logic [3:0]            hex_val;
  logic [7:0]            oct_next;
  logic [1:0]            cnt_next;

  function automatic c_esc_pkg::res_t byte_word(input logic [7:0] b);
    c_esc_pkg::res_t r;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.literal_end = 1'b0;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] esc_char(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      CH_LO_N: m = 8'h0A;
      CH_LO_A: m = 8'h07;
      CH_LO_B: m = 8'h08;
      CH_LO_F: m = 8'h0C;
      CH_LO_R: m = 8'h0D;
      CH_LO_T: m = 8'h09;
      CH_LO_V: m = 8'h0B;
      default: m = c;
    endcase
    return m;
  endfunction

  always_comb begin
    is_oct   = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_SEVEN);
    is_hex   = ((in_byte_i >= CH_ZERO) && (in_byte_i <= CH_NINE)) ||
               ((in_byte_i >= CH_LO_A) && (in_byte_i <= CH_LO_F)) ||
               ((in_byte_i >= CH_UP_A) && (in_byte_i <= CH_UP_F));
    // Letters carry their value minus nine in the low nibble.
    hex_val  = (in_byte_i <= CH_NINE) ? in_byte_i[3:0] : in_byte_i[3:0] + 4'd9;
    oct_next = {state_q.value[4:0], 3'b000} + {5'd0, in_byte_i[2:0]};
    cnt_next = state_q.oct_cnt + 2'd1;

    state_d  = state_q;
    res[0]   = '0;
    res[1]   = '0;
    n_res    = 2'd0;
    do_plain = 1'b0;

    case (state_q.mode)
      c_esc_pkg::MODE_TEXT: begin
        do_plain = 1'b1;
      end
      c_esc_pkg::MODE_ESC: begin
        if (is_oct) begin
          state_d.mode    = c_esc_pkg::MODE_OCT;
          state_d.value   = {5'd0, in_byte_i[2:0]};
          state_d.oct_cnt = 2'd1;
        end else if (in_byte_i == CH_LO_X) begin
          state_d.mode  = c_esc_pkg::MODE_HEX;
          state_d.value = 8'd0;
        end else begin
          state_d.mode   = c_esc_pkg::MODE_TEXT;
          res[n_res[0]]  = byte_word(esc_char(in_byte_i));
          n_res          = n_res + 2'd1;
        end
      end
      c_esc_pkg::MODE_OCT: begin
        if (is_oct) begin
          if (cnt_next == OCT_MAX) begin
            res[n_res[0]] = byte_word(oct_next);
            n_res         = n_res + 2'd1;
            state_d       = STATE_RST;
          end else begin
            state_d.value   = oct_next;
            state_d.oct_cnt = cnt_next;
          end
        end else begin
          res[n_res[0]] = byte_word(state_q.value);
          n_res         = n_res + 2'd1;
          state_d       = STATE_RST;
          do_plain      = 1'b1;
        end
      end
      c_esc_pkg::MODE_HEX: begin
        if (is_hex) begin
          state_d.value = {state_q.value[3:0], hex_val};
        end else begin
          res[n_res[0]] = byte_word(state_q.value);
          n_res         = n_res + 2'd1;
          state_d       = STATE_RST;
          do_plain      = 1'b1;
        end
      end
      default: begin
        state_d = STATE_RST;
      end
    endcase

    if (do_plain) begin
      if (in_byte_i == CH_BSLASH) begin
        state_d.mode = c_esc_pkg::MODE_ESC;
      end else begin
        res[n_res[0]] = byte_word(in_byte_i);
        n_res         = n_res + 2'd1;
      end
    end

    if (is_final_i) begin
      // Flush a pending numeric escape, then make sure the end marker has a word.
      if ((state_d.mode == c_esc_pkg::MODE_OCT) || (state_d.mode == c_esc_pkg::MODE_HEX)) begin
        res[n_res[0]] = byte_word(state_d.value);
        n_res         = n_res + 2'd1;
      end
      if (n_res == 2'd0) begin
        n_res = 2'd1;
      end
      res[n_res[1]].literal_end = 1'b1;
      state_d = STATE_RST;
    end

    if (n_res != 2'd0) begin
      res[n_res[1]].run_last = 1'b1;
    end

    push_o.count  = en_i ? n_res : 2'd0;
    push_o.first  = res[0];
    push_o.second = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

FILE: src/c_esc_res_fifo.sv
// Result queue that takes up to two words a cycle and hands out one while the output side is ready.
module c_esc_res_fifo #(
  parameter int unsigned DEPTH = c_esc_pkg::RES_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  c_esc_pkg::dec_push_t push_i,
  output logic                 room_o,
  c_esc_res_if.source          res_o
);

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  c_esc_pkg::res_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CW-1:0]   count_q, count_d;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop       = res_o.valid && res_o.ready;
  assign wr_ptr_nx = ptr_inc(wr_ptr_q);

  always_comb begin
    case (push_i.count)
      2'd0:    wr_ptr_d = wr_ptr_q;
      2'd1:    wr_ptr_d = wr_ptr_nx;
      default: wr_ptr_d = ptr_inc(wr_ptr_nx);
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push_i.count) - CW'(pop);
  end

  // Room for two words, whatever the output side does this cycle.
  assign room_o = (count_q <= CW'(DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

  assign res_o.valid       = (count_q != '0);
  assign res_o.out_byte    = mem_q[rd_ptr_q].out_byte;
  assign res_o.byte_valid  = mem_q[rd_ptr_q].byte_valid;
  assign res_o.literal_end = mem_q[rd_ptr_q].literal_end;
  assign res_o.run_last    = mem_q[rd_ptr_q].run_last;

endmodule

FILE: src/c_escape_sequence_decoder_top.sv
// Top level of the C string escape sequence decoder.
// This block takes the raw bytes of one C character or string literal, one
// byte per word on byte_in_i with is_final on the last byte, and returns the
// decoded bytes as words on result_o. Backslash escapes are resolved: one to
// three octal digits, \x with any number of hex digits (a bare \x gives
// zero), both truncated to 8 bits, and the usual letter escapes; an unknown
// letter passes as itself and a trailing backslash yields no byte. Every
// input byte causes zero, one or two result words; run_last marks the last
// word caused by a byte, and literal_end marks the final word of a literal,
// which may carry no byte (byte_valid low). A byte is taken into an input
// register, decoded by a single pass of logic against the escape state once
// the small result queue has room for both of its words, and its words are
// written into that queue, whose head drives result_o. The input accepts one
// byte every cycle as long as the queue has room for two words; since
// result_o moves one word per cycle while its receiver is ready, the
// sustained input rate is one byte per cycle when each byte yields at most
// one word, and bytes that yield two words slow it down.

`include "c_escape_sequence_decoder_top_macros.svh"

module c_escape_sequence_decoder_top #(
  parameter int unsigned RES_DEPTH = c_esc_pkg::RES_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  c_esc_byte_if.sink   byte_in_i,
  c_esc_res_if.source  result_o
);

  // Input register: one raw byte waiting for its decode pass.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_final_q;

  logic                  res_room;
  logic                  advance;
  logic                  in_accept;
  c_esc_pkg::dec_push_t  push;
  c_esc_pkg::dec_state_t dec_state;

  // The held byte is decoded when the queue can take both of its words.
  assign advance         = s1_valid_q && res_room;
  assign byte_in_i.ready = !s1_valid_q || res_room;
  assign in_accept       = byte_in_i.valid && byte_in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= byte_in_i.in_byte;
      s1_final_q <= byte_in_i.is_final;
    end
  end

  c_esc_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .in_byte_i  (s1_byte_q),
    .is_final_i (s1_final_q),
    .push_o     (push),
    .state_o    (dec_state)
  );

  c_esc_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (res_room),
    .res_o  (result_o)
  );

  // A finished literal leaves the escape state at its reset values.
  `C_ESC_ASSERT_NEXT(a_final_clears_state, advance && s1_final_q,
    (dec_state.mode == c_esc_pkg::MODE_TEXT) && (dec_state.value == 8'd0) &&
    (dec_state.oct_cnt == 2'd0))

  // The octal digit count is live only while octal digits are pending.
  `C_ESC_ASSERT_IMP(a_oct_count_range, 1'b1,
    (dec_state.mode == c_esc_pkg::MODE_OCT) ?
    ((dec_state.oct_cnt == 2'd1) || (dec_state.oct_cnt == 2'd2)) :
    (dec_state.oct_cnt == 2'd0))

  // A word without a byte only ever marks the end of a literal.
  `C_ESC_ASSERT_IMP(a_empty_word_is_end, result_o.valid && !result_o.byte_valid,
    result_o.literal_end && result_o.run_last && (result_o.out_byte == 8'd0))

  // A decode pass always finds room for its words.
  `C_ESC_ASSERT_IMP(a_push_needs_room, push.count != 2'd0, res_room && advance)

endmodule
